[hw/rtl/bpc_pkg.sv]
`timescale 1ns / 1ps
package bpc_pkg;

  // Pipeline depth and field widths
  localparam int NSTG = 7;
  localparam int CW   = 16;  // calibration word
  localparam int DW   = 24;  // raw conversion
  localparam int TW   = 19;  // temperature result
  localparam int PW   = 28;  // pressure result
  localparam int OW   = 42;  // offset and sensitivity terms
  localparam int IW   = 3;   // register index

  // Band limits in hundredths of a degree
  localparam logic signed [19:0] T_REF = 20'sd2000;
  localparam logic signed [19:0] T_LOW = -20'sd1500;

  // Calibration register indexes
  typedef enum logic [IW-1:0] {
    REG_SENS_T1   = 3'd0,
    REG_OFF_T1    = 3'd1,
    REG_TCS       = 3'd2,
    REG_TCO       = 3'd3,
    REG_TREF      = 3'd4,
    REG_TEMPSENS  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CW-1:0] sens_t1;
    logic [CW-1:0] off_t1;
    logic [CW-1:0] tcs;
    logic [CW-1:0] tco;
    logic [CW-1:0] tref;
    logic [CW-1:0] tempsens;
  } coef_t;

  // Per-stage load strobes and valid bits
  typedef struct packed {
    logic [NSTG-1:0] ld;
    logic [NSTG-1:0] vld;
  } pipe_ctl_t;

  // Handoff from the temperature half to the pressure half
  typedef struct packed {
    logic [DW-1:0]        d1;
    logic signed [OW-1:0] off_base;
    logic signed [OW-1:0] sens_base;
    logic signed [OW-1:0] tdsq;
    logic signed [OW-1:0] tlsq;
    logic                 lt_ref;
    logic                 lt_low;
    logic signed [TW-1:0] temp;
  } corr_t;

endpackage

[hw/rtl/baro_pressure_temp_compensation.sv]
`timescale 1ns / 1ps
// Second-order compensation for a piezoresistive barometer. Each input
// transaction carries a raw 24-bit pressure and temperature conversion; each
// output transaction returns the temperature in hundredths of a degree C and
// the pressure in hundredths of a millibar, computed from the six calibration
// words in the configuration registers. The block takes one transaction per
// cycle while the output is not stalled and passes each through the seven
// register stages (difference, products, scaling, band squares, correction,
// split pressure multiply, output register), the first of which captures the
// input at the accepting edge. Write calibration words only
// while no transaction is in flight.
module baro_pressure_temp_compensation (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: raw_pressure [23:0], raw_temperature [47:24]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [47:0]            in_tdata,
  // out_tdata: temp_centideg [18:0], pressure_centimbar [46:19], zero [47]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [47:0]            out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [bpc_pkg::IW-1:0] cfg_index,
  input  logic [bpc_pkg::CW-1:0] cfg_data
);
  import bpc_pkg::*;

  coef_t                coef;
  pipe_ctl_t            ctl;
  corr_t                corr;
  logic signed [TW-1:0] temp;
  logic signed [PW-1:0] press;

  bpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  bpc_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .ctl       (ctl)
  );

  bpc_temp_path u_temp (
    .clk  (clk),
    .ctl  (ctl),
    .coef (coef),
    .d1   (in_tdata[23:0]),
    .d2   (in_tdata[47:24]),
    .corr (corr)
  );

  bpc_press_path u_press (
    .clk   (clk),
    .ctl   (ctl),
    .corr  (corr),
    .temp  (temp),
    .press (press)
  );

  assign out_tvalid = ctl.vld[NSTG-1];
  assign out_tdata  = {1'b0, press, temp};

  // An empty output stage never blocks the input
  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");

  // Accept without delivery adds exactly one item in flight
  a_fill_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !(out_tvalid && out_tready)) |=>
      $countones(ctl.vld) == $past($countones(ctl.vld)) + 1)
    else $error("item count did not grow on accept");

  // Delivery without accept removes exactly one item in flight
  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!(in_tvalid && in_tready) && out_tvalid && out_tready) |=>
      $countones(ctl.vld) + 1 == $past($countones(ctl.vld)))
    else $error("item count did not shrink on delivery");

endmodule

[hw/rtl/bpc_cfg_regs.sv]
`timescale 1ns / 1ps
module bpc_cfg_regs (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [bpc_pkg::IW-1:0] cfg_index,
  input  logic [bpc_pkg::CW-1:0] cfg_data,
  output bpc_pkg::coef_t        coef
);
  import bpc_pkg::*;

  coef_t coef_r;

  // Always take a write; unknown indexes are dropped
  assign cfg_ready = 1'b1;
  assign coef      = coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SENS_T1:  coef_r.sens_t1  <= cfg_data;
        REG_OFF_T1:   coef_r.off_t1   <= cfg_data;
        REG_TCS:      coef_r.tcs      <= cfg_data;
        REG_TCO:      coef_r.tco      <= cfg_data;
        REG_TREF:     coef_r.tref     <= cfg_data;
        REG_TEMPSENS: coef_r.tempsens <= cfg_data;
        default:      coef_r          <= coef_r;
      endcase
    end
  end

endmodule

[hw/rtl/bpc_pipe_ctrl.sv]
`timescale 1ns / 1ps
module bpc_pipe_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output bpc_pkg::pipe_ctl_t   ctl
);
  import bpc_pkg::*;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG-1:0] rdy;
  logic [NSTG-1:0] ld;

  // A stage can take new data when empty or when its content moves on
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int s = NSTG - 2; s >= 0; s--) begin
      rdy[s] = !vld_r[s] || rdy[s+1];
    end
  end

  // Load strobes and next valid bits
  always_comb begin
    ld[0]      = rdy[0] && in_valid;
    vld_nxt[0] = rdy[0] ? in_valid : vld_r[0];
    for (int s = 1; s < NSTG; s++) begin
      ld[s]      = rdy[s] && vld_r[s-1];
      vld_nxt[s] = rdy[s] ? vld_r[s-1] : vld_r[s];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready = rdy[0];
  assign ctl.ld   = ld;
  assign ctl.vld  = vld_r;

endmodule

[hw/rtl/bpc_temp_path.sv]
`timescale 1ns / 1ps
module bpc_temp_path (
  input  logic                   clk,
  input  bpc_pkg::pipe_ctl_t     ctl,
  input  bpc_pkg::coef_t         coef,
  input  logic [bpc_pkg::DW-1:0] d1,
  input  logic [bpc_pkg::DW-1:0] d2,
  output bpc_pkg::corr_t         corr
);
  import bpc_pkg::*;

  // Stage 0: temperature difference
  logic [DW-1:0]        d1_s0_r;
  logic signed [24:0]   dt_s0_r;
  logic signed [24:0]   dt_nxt;

  // Stage 1: products of dT
  logic [DW-1:0]        d1_s1_r;
  logic signed [41:0]   prod_t_s1_r, prod_t_nxt;
  logic signed [49:0]   dtsq_s1_r, dtsq_nxt;
  logic signed [41:0]   off_lin_s1_r, off_lin_nxt;
  logic signed [41:0]   sens_lin_s1_r, sens_lin_nxt;

  // Stage 2: first-order temperature, second-order T2 candidates, base terms
  logic [DW-1:0]        d1_s2_r;
  logic signed [19:0]   temp_s2_r, temp_nxt;
  logic signed [19:0]   t2a_s2_r, t2a_nxt;
  logic signed [19:0]   t2b_s2_r, t2b_nxt;
  logic signed [OW-1:0] off_base_s2_r, off_base_nxt;
  logic signed [OW-1:0] sens_base_s2_r, sens_base_nxt;
  logic signed [51:0]   dtsq3;
  logic signed [52:0]   dtsq5;

  // Stage 3: band squares and output temperature
  corr_t                corr_r, corr_nxt;
  logic signed [20:0]   tdiff;
  logic signed [20:0]   tlow;
  logic signed [20:0]   temp_out;

  assign dt_nxt = $signed({1'b0, d2}) - $signed({1'b0, coef.tref, 8'b0});

  always_ff @(posedge clk) begin
    if (ctl.ld[0]) begin
      d1_s0_r <= d1;
      dt_s0_r <= dt_nxt;
    end
  end

  // Multiply dT by C6, by itself, by C4 and by C3
  always_comb begin
    prod_t_nxt   = dt_s0_r * $signed({1'b0, coef.tempsens});
    dtsq_nxt     = dt_s0_r * dt_s0_r;
    off_lin_nxt  = $signed({1'b0, coef.tco}) * dt_s0_r;
    sens_lin_nxt = $signed({1'b0, coef.tcs}) * dt_s0_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[1]) begin
      d1_s1_r       <= d1_s0_r;
      prod_t_s1_r   <= prod_t_nxt;
      dtsq_s1_r     <= dtsq_nxt;
      off_lin_s1_r  <= off_lin_nxt;
      sens_lin_s1_r <= sens_lin_nxt;
    end
  end

  // Scale and add the constant parts
  always_comb begin
    temp_nxt      = 20'(prod_t_s1_r >>> 23) + T_REF;
    dtsq3         = (52'(dtsq_s1_r) <<< 1) + 52'(dtsq_s1_r);
    dtsq5         = (53'(dtsq_s1_r) <<< 2) + 53'(dtsq_s1_r);
    t2a_nxt       = 20'(dtsq3 >>> 33);
    t2b_nxt       = 20'(dtsq5 >>> 38);
    off_base_nxt  = $signed({9'b0, coef.off_t1, 17'b0}) + OW'(off_lin_s1_r >>> 6);
    sens_base_nxt = $signed({10'b0, coef.sens_t1, 16'b0}) + OW'(sens_lin_s1_r >>> 7);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[2]) begin
      d1_s2_r        <= d1_s1_r;
      temp_s2_r      <= temp_nxt;
      t2a_s2_r       <= t2a_nxt;
      t2b_s2_r       <= t2b_nxt;
      off_base_s2_r  <= off_base_nxt;
      sens_base_s2_r <= sens_base_nxt;
    end
  end

  // Pick the T2 band and square the band distances
  always_comb begin
    tdiff              = 21'(temp_s2_r) - 21'(T_REF);
    tlow               = 21'(temp_s2_r) - 21'(T_LOW);
    corr_nxt.lt_ref    = temp_s2_r < T_REF;
    corr_nxt.lt_low    = temp_s2_r < T_LOW;
    temp_out           = 21'(temp_s2_r) - (corr_nxt.lt_ref ? 21'(t2a_s2_r) : 21'(t2b_s2_r));
    corr_nxt.temp      = TW'(temp_out);
    corr_nxt.tdsq      = OW'(tdiff * tdiff);
    corr_nxt.tlsq      = OW'(tlow * tlow);
    corr_nxt.d1        = d1_s2_r;
    corr_nxt.off_base  = off_base_s2_r;
    corr_nxt.sens_base = sens_base_s2_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[3]) begin
      corr_r <= corr_nxt;
    end
  end

  assign corr = corr_r;

endmodule

[hw/rtl/bpc_press_path.sv]
`timescale 1ns / 1ps
module bpc_press_path (
  input  logic                          clk,
  input  bpc_pkg::pipe_ctl_t            ctl,
  input  bpc_pkg::corr_t                corr,
  output logic signed [bpc_pkg::TW-1:0] temp,
  output logic signed [bpc_pkg::PW-1:0] press
);
  import bpc_pkg::*;

  // Stage 4: corrected offset and sensitivity
  logic [DW-1:0]        d1_s4_r;
  logic signed [TW-1:0] temp_s4_r;
  logic signed [OW-1:0] off_s4_r, off_nxt;
  logic signed [OW-1:0] sens_s4_r, sens_nxt;
  logic signed [47:0]   off2, sens2;
  logic signed [47:0]   tdsq_w, tlsq_w;

  // Stage 5: partial products of D1 and SENS
  logic signed [TW-1:0] temp_s5_r;
  logic signed [OW-1:0] off_s5_r;
  logic [44:0]          pp_lo_s5_r, pp_lo_nxt;
  logic signed [45:0]   pp_hi_s5_r, pp_hi_nxt;

  // Stage 6: output register
  logic signed [TW-1:0] temp_s6_r;
  logic signed [PW-1:0] press_s6_r, press_nxt;
  logic signed [65:0]   full;
  logic signed [65:0]   diff;

  // Subtract the second-order offset and sensitivity by band
  always_comb begin
    tdsq_w = 48'(corr.tdsq);
    tlsq_w = 48'(corr.tlsq);
    off2   = '0;
    sens2  = '0;
    if (corr.lt_ref) begin
      off2  = ((tdsq_w <<< 6) - (tdsq_w <<< 1) - tdsq_w) >>> 4;
      sens2 = ((tdsq_w <<< 5) - (tdsq_w <<< 1) - tdsq_w) >>> 4;
      if (corr.lt_low) begin
        off2  = off2 + (tlsq_w <<< 4) + tlsq_w;
        sens2 = sens2 + (tlsq_w <<< 3) + tlsq_w;
      end
    end
    off_nxt  = OW'(48'(corr.off_base) - off2);
    sens_nxt = OW'(48'(corr.sens_base) - sens2);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[4]) begin
      d1_s4_r   <= corr.d1;
      temp_s4_r <= corr.temp;
      off_s4_r  <= off_nxt;
      sens_s4_r <= sens_nxt;
    end
  end

  // Split SENS into an unsigned low half and a signed high half
  always_comb begin
    pp_lo_nxt = d1_s4_r * sens_s4_r[20:0];
    pp_hi_nxt = $signed({1'b0, d1_s4_r}) * $signed(sens_s4_r[OW-1:21]);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[5]) begin
      temp_s5_r  <= temp_s4_r;
      off_s5_r   <= off_s4_r;
      pp_lo_s5_r <= pp_lo_nxt;
      pp_hi_s5_r <= pp_hi_nxt;
    end
  end

  // Recombine, scale and subtract OFF
  always_comb begin
    full      = (66'(pp_hi_s5_r) <<< 21) + $signed({21'b0, pp_lo_s5_r});
    diff      = (full >>> 21) - 66'(off_s5_r);
    press_nxt = PW'(diff >>> 15);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld[6]) begin
      temp_s6_r  <= temp_s5_r;
      press_s6_r <= press_nxt;
    end
  end

  assign temp  = temp_s6_r;
  assign press = press_s6_r;

endmodule
